// File: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define DFRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define DFRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dfra_pkg.sv
// Shared widths, defaults, command codes and control structs of the allocator.
`timescale 1ns / 1ps
`default_nettype none
package dfra_pkg;

  // Word field widths
  localparam int CMD_W  = 2;
  localparam int SIZE_W = 7;
  localparam int NODE_W = 8;

  // Default machine shape
  localparam int DEF_GROUPS            = 8;
  localparam int DEF_ROUTERS_PER_GROUP = 8;
  localparam int DEF_NODES_PER_ROUTER  = 4;
  localparam int DEF_MAX_JOB           = 64;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_BUSY  = 2'd1,
    CMD_FREE  = 2'd2
  } dfra_cmd_t;

  // Mark request toward the free map
  typedef struct packed {
    logic valid;
    logic set_free;
  } dfra_mark_t;

  // Free map status
  typedef struct packed {
    logic ready;     // no clear pass and no mark in flight
    logic clearing;  // post-reset fill still running
  } dfra_map_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/dfra_ifs.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface dfra_in_if;
  import dfra_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] job_size;
  logic [NODE_W-1:0] node_index;
  modport source (output valid, command, job_size, node_index, input ready);
  modport sink   (input valid, command, job_size, node_index, output ready);
endinterface

interface dfra_out_if;
  import dfra_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_id;
  logic              failed;
  logic              last;
  modport source (output valid, node_id, failed, last, input ready);
  modport sink   (input valid, node_id, failed, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dfra_free_map.sv
// Node free map: one-bit-per-node RAM, reset fill, mark read-modify-write, free count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfra_free_map #(
  parameter int TOTAL = 256,
  parameter int NA_W  = 8,
  parameter int CNT_W = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dfra_pkg::dfra_mark_t     mark_req,
  input  wire logic [NA_W-1:0]          mark_addr,
  input  wire logic                     scan_rd_en,
  input  wire logic [NA_W-1:0]          scan_rd_addr,
  output      logic                     rd_free,
  output      logic [CNT_W-1:0]         free_count,
  output      dfra_pkg::dfra_map_stat_t map_stat
);
  import dfra_pkg::*;

  logic             mem [TOTAL];
  logic             rd_q_r;
  logic             clr_r;
  logic [NA_W-1:0]  clr_idx_r;
  logic             mk_pend_r;
  logic             mk_free_r;
  logic [NA_W-1:0]  mk_addr_r;
  logic [CNT_W-1:0] cnt_r;

  logic             rd_en;
  logic [NA_W-1:0]  rd_addr;
  logic             wr_en;
  logic [NA_W-1:0]  wr_addr;
  logic             wr_bit;

  // Read port: a mark request wins over the scan (they never coincide)
  assign rd_en   = mark_req.valid | scan_rd_en;
  assign rd_addr = mark_req.valid ? mark_addr : scan_rd_addr;

  // Write port: reset fill, else mark write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx_r;
    wr_bit  = 1'b1;
    if (clr_r) begin
      wr_en = 1'b1;
    end else if (mk_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = mk_addr_r;
      wr_bit  = mk_free_r;
    end
  end

  // RAM with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_bit;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  // Fill sweep, mark pipeline and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      mk_pend_r <= 1'b0;
      cnt_r     <= CNT_W'(TOTAL);
    end else begin
      if (clr_r) begin
        if (clr_idx_r == NA_W'(TOTAL - 1)) clr_r <= 1'b0;
        clr_idx_r <= clr_idx_r + NA_W'(1);
      end
      mk_pend_r <= mark_req.valid;
      if (mark_req.valid) begin
        mk_free_r <= mark_req.set_free;
        mk_addr_r <= mark_addr;
      end
      // redundant marks leave the count alone
      if (mk_pend_r && (rd_q_r != mk_free_r)) begin
        cnt_r <= mk_free_r ? cnt_r + CNT_W'(1) : cnt_r - CNT_W'(1);
      end
    end
  end

  assign rd_free           = rd_q_r;
  assign free_count        = cnt_r;
  assign map_stat.ready    = !clr_r && !mk_pend_r;
  assign map_stat.clearing = clr_r;

  `DFRA_ASSERT_IMP(a_mark_not_in_fill, mk_pend_r, !clr_r, "mark during fill sweep")
  `DFRA_ASSERT_IMP(a_count_range, 1'b1, 32'(cnt_r) <= 32'(TOTAL), "free count above node total")
  `DFRA_ASSERT_NXT(a_count_quiet, !mk_pend_r, cnt_r == $past(cnt_r),
                   "free count moved without a mark")

endmodule
`default_nettype wire

// File: rtl/core/dragonfly_round_robin_router_allocator_unit.sv
// Top level: dragonfly round-robin node allocator, command decode and scan sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Usage
//   in_ch takes command words: allocate (job_size), mark busy or mark free
//   (node_index). out_ch gives one word per node taken by an allocate, the
//   final one flagged last; a job that cannot be placed gives one word with
//   failed and last set and node_id zero. Marks give no word.
// Timing
//   A mark holds in_ch.ready low while it writes back the bit read at the
//   accepting edge. An allocate walks the free map RAM one node per cycle,
//   its single read port setting the pace, save while a free node waits on
//   a full output register. Each group visit passes through S_GRP before
//   its nodes are checked in S_CHK; the first free node checked is loaded
//   into the output register as the first word.
// Reset
//   After rst_n the RAM is filled with ones, one node per cycle; in_ch.ready
//   stays low until all TOTAL nodes (256 at default shape) are filled.
// Backpressure
//   Results pass through one output register; while it is full and
//   out_ch.ready is low the scan stops at the next free node. A new command
//   is taken while the last word of the previous one still waits.
module dragonfly_round_robin_router_allocator_unit #(
  parameter int GROUPS            = dfra_pkg::DEF_GROUPS,
  parameter int ROUTERS_PER_GROUP = dfra_pkg::DEF_ROUTERS_PER_GROUP,
  parameter int NODES_PER_ROUTER  = dfra_pkg::DEF_NODES_PER_ROUTER,
  parameter int MAX_JOB           = dfra_pkg::DEF_MAX_JOB
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dfra_in_if.sink   in_ch,
  dfra_out_if.source out_ch
);
  import dfra_pkg::*;

  localparam int NPG   = ROUTERS_PER_GROUP * NODES_PER_ROUTER;
  localparam int TOTAL = GROUPS * NPG;
  localparam int NA_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNT_W = $clog2(TOTAL + 1);
  localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int RT_W  = (ROUTERS_PER_GROUP > 1) ? $clog2(ROUTERS_PER_GROUP) : 1;
  localparam int K_W   = (NODES_PER_ROUTER > 1) ? $clog2(NODES_PER_ROUTER) : 1;
  localparam int PTR_W = $clog2(ROUTERS_PER_GROUP + 1);
  localparam int ASG_W = $clog2(MAX_JOB + 1);

  typedef enum logic [1:0] {S_IDLE, S_FAIL, S_GRP, S_CHK} state_t;

  state_t           state_r;
  logic [ASG_W-1:0] size_r;
  logic [ASG_W-1:0] asg_r;
  logic [GRP_W-1:0] grp_r;
  logic [RT_W-1:0]  rt_r;
  logic [K_W-1:0]   k_r;
  logic [NA_W-1:0]  node_r;
  logic             found_r;
  logic [PTR_W-1:0] ptr_r [GROUPS];   // next unvisited router per group, this job
  logic             out_valid_r;
  logic [NODE_W-1:0] out_node_r;
  logic             out_failed_r;
  logic             out_last_r;

  dfra_mark_t       mark_req;
  dfra_map_stat_t   map_stat;
  logic [NA_W-1:0]  mark_addr;
  logic             scan_rd_en;
  logic [NA_W-1:0]  scan_rd_addr;
  logic             rd_free;
  logic [CNT_W-1:0] free_count;

  logic             in_acc;
  logic             slot_free;
  logic             cmd_mark;
  logic             idx_ok;
  logic             job_bad;
  logic [PTR_W-1:0] grp_ptr;
  logic [NA_W-1:0]  grp_start;
  logic [GRP_W-1:0] grp_next;
  logic             emit;
  logic             advance;
  logic [ASG_W-1:0] asg_inc;
  logic             job_done;
  logic             last_k;
  logic             rt_end;
  logic             out_load;

  assign in_ch.ready = (state_r == S_IDLE) && map_stat.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Command decode
  always_comb begin
    cmd_mark          = 1'b0;
    mark_req.set_free = 1'b0;
    unique case (dfra_cmd_t'(in_ch.command))
      CMD_BUSY: cmd_mark = 1'b1;
      CMD_FREE: begin
        cmd_mark          = 1'b1;
        mark_req.set_free = 1'b1;
      end
      default: cmd_mark = 1'b0;
    endcase
    mark_req.valid = in_acc && cmd_mark && idx_ok;
  end

  assign idx_ok         = 32'(in_ch.node_index) < 32'(TOTAL);
  assign mark_addr      = NA_W'(in_ch.node_index);
  assign job_bad        = (in_ch.job_size == '0) || (32'(in_ch.job_size) > 32'(MAX_JOB))
                          || (32'(in_ch.job_size) > 32'(free_count));

  // Group entry address: first node of the next unvisited router
  assign grp_ptr   = ptr_r[grp_r];
  assign grp_start = NA_W'(32'(grp_r) * NPG + 32'(grp_ptr) * NODES_PER_ROUTER);
  assign grp_next  = (grp_r == GRP_W'(GROUPS - 1)) ? '0 : grp_r + GRP_W'(1);

  // Node check step
  assign emit     = (state_r == S_CHK) && rd_free && slot_free;
  assign advance  = (state_r == S_CHK) && (!rd_free || slot_free);
  assign asg_inc  = asg_r + ASG_W'(1);
  assign job_done = emit && (asg_inc == size_r);
  assign last_k   = (k_r == K_W'(NODES_PER_ROUTER - 1));
  assign rt_end   = last_k && (found_r || emit || (rt_r == RT_W'(ROUTERS_PER_GROUP - 1)));
  assign out_load = emit || ((state_r == S_FAIL) && slot_free);

  // RAM read requests from the sequencer
  always_comb begin
    scan_rd_en   = 1'b0;
    scan_rd_addr = node_r + NA_W'(1);
    if (state_r == S_GRP) begin
      scan_rd_en   = (grp_ptr != PTR_W'(ROUTERS_PER_GROUP));
      scan_rd_addr = grp_start;
    end else if (advance && !job_done && !rt_end) begin
      scan_rd_en = 1'b1;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load a new word, else drop the one taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (dfra_cmd_t'(in_ch.command) == CMD_ALLOC)) begin
            if (job_bad) begin
              state_r <= S_FAIL;
            end else begin
              size_r  <= ASG_W'(in_ch.job_size);
              asg_r   <= '0;
              grp_r   <= '0;
              for (int g = 0; g < GROUPS; g++) ptr_r[g] <= '0;
              state_r <= S_GRP;
            end
          end
        end
        S_FAIL: begin
          if (slot_free) begin
            out_node_r   <= '0;
            out_failed_r <= 1'b1;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_GRP: begin
          if (grp_ptr == PTR_W'(ROUTERS_PER_GROUP)) begin
            grp_r <= grp_next;
          end else begin
            node_r  <= grp_start;
            rt_r    <= RT_W'(grp_ptr);
            k_r     <= '0;
            found_r <= 1'b0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (emit) begin
            out_node_r   <= NODE_W'(node_r);
            out_failed_r <= 1'b0;
            out_last_r   <= job_done;
            asg_r        <= asg_inc;
            found_r      <= 1'b1;
          end
          if (advance) begin
            if (job_done) begin
              state_r <= S_IDLE;
            end else if (rt_end) begin
              ptr_r[grp_r] <= PTR_W'(rt_r) + PTR_W'(1);
              grp_r        <= grp_next;
              state_r      <= S_GRP;
            end else begin
              node_r <= node_r + NA_W'(1);
              if (last_k) begin
                k_r  <= '0;
                rt_r <= rt_r + RT_W'(1);
              end else begin
                k_r <= k_r + K_W'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.node_id = out_node_r;
  assign out_ch.failed  = out_failed_r;
  assign out_ch.last    = out_last_r;

  dfra_free_map #(
    .TOTAL (TOTAL),
    .NA_W  (NA_W),
    .CNT_W (CNT_W)
  ) u_map (
    .clk          (clk),
    .rst_n        (rst_n),
    .mark_req     (mark_req),
    .mark_addr    (mark_addr),
    .scan_rd_en   (scan_rd_en),
    .scan_rd_addr (scan_rd_addr),
    .rd_free      (rd_free),
    .free_count   (free_count),
    .map_stat     (map_stat)
  );

  `DFRA_ASSERT_IMP(a_accept_map_ready, in_ch.valid && in_ch.ready, map_stat.ready,
                   "command taken while free map busy")
  `DFRA_ASSERT_IMP(a_chk_below_size, state_r == S_CHK, asg_r < size_r,
                   "scan running with job already full")
  `DFRA_ASSERT_IMP(a_fail_word, out_valid_r && out_failed_r,
                   out_last_r && (out_node_r == '0), "failed word not last or nonzero node")
  `DFRA_ASSERT_IMP(a_quiet_in_fill, map_stat.clearing,
                   !out_valid_r && (state_r == S_IDLE), "activity during fill sweep")

endmodule
`default_nettype wire

// File: test/dragonfly_round_robin_router_allocator_unit_test.sv
// Self-checking bench for the dragonfly round-robin node allocator.
`timescale 1ns / 1ps

module dragonfly_round_robin_router_allocator_unit_test;
  import dfra_pkg::*;

  // Machine shape, same as the block's defaults
  localparam int GROUPS           = DEF_GROUPS;
  localparam int ROUTERS          = DEF_ROUTERS_PER_GROUP;
  localparam int NODES_PER_ROUTER = DEF_NODES_PER_ROUTER;
  localparam int MAX_JOB          = DEF_MAX_JOB;
  localparam int NODES_PER_GROUP  = ROUTERS * NODES_PER_ROUTER;
  localparam int TOTAL            = GROUPS * NODES_PER_GROUP;

  // Command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 600;                      // long output stall
  localparam int DRAIN_CYCLES = TOTAL + 2 * GROUPS + 16;  // one full scan
  localparam int PHASE_WORDS  = 50;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SIZE_W-1:0] job_size;
    logic [NODE_W-1:0] node_index;
  } cmd_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              failed;
    logic              last;
  } alloc_word_t;

  typedef struct packed {
    cmd_word_t   w;
    logic        fixed_on;
    alloc_word_t fixed;
  } directed_row_t;

  localparam alloc_word_t FAIL_WORD = '{node_id: '0, failed: 1'b1, last: 1'b1};
  localparam alloc_word_t NO_WORD   = '0;

  // Directed words; fixed results only where they are obvious
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{CMD_ALLOC,  7'd1,   8'h00}, 1'b1, '{8'd0, 1'b0, 1'b1}},  // first free node
    '{'{CMD_ALLOC,  7'd0,   8'hff}, 1'b1, FAIL_WORD},            // empty job
    '{'{CMD_ALLOC,  7'd65,  8'h00}, 1'b1, FAIL_WORD},            // just over the max
    '{'{CMD_ALLOC,  7'd127, 8'hff}, 1'b1, FAIL_WORD},            // all size bits set
    '{'{CMD_ALLOC,  7'd64,  8'h5a}, 1'b0, NO_WORD},              // largest job
    '{'{CMD_UNUSED, 7'd127, 8'hff}, 1'b0, NO_WORD},              // ignored command
    '{'{CMD_BUSY,   7'h55,  8'h00}, 1'b0, NO_WORD},
    '{'{CMD_BUSY,   7'h2a,  8'h00}, 1'b0, NO_WORD},              // already busy
    '{'{CMD_ALLOC,  7'd1,   8'h00}, 1'b1, '{8'd1, 1'b0, 1'b1}},  // skips busy node 0
    '{'{CMD_FREE,   7'h7f,  8'h00}, 1'b0, NO_WORD},
    '{'{CMD_FREE,   7'h00,  8'h00}, 1'b0, NO_WORD},              // already free
    '{'{CMD_BUSY,   7'h55,  8'hff}, 1'b0, NO_WORD},
    '{'{CMD_ALLOC,  7'd64,  8'hff}, 1'b0, NO_WORD},
    '{'{CMD_FREE,   7'h2a,  8'hff}, 1'b0, NO_WORD},
    '{'{CMD_BUSY,   7'h01,  8'h00}, 1'b0, NO_WORD},              // empty router 0
    '{'{CMD_BUSY,   7'h02,  8'h01}, 1'b0, NO_WORD},
    '{'{CMD_BUSY,   7'h04,  8'h02}, 1'b0, NO_WORD},
    '{'{CMD_BUSY,   7'h08,  8'h03}, 1'b0, NO_WORD},
    '{'{CMD_ALLOC,  7'd5,   8'h33}, 1'b0, NO_WORD},
    '{'{CMD_ALLOC,  7'd2,   8'hcc}, 1'b0, NO_WORD},
    '{'{CMD_FREE,   7'h10,  8'h00}, 1'b0, NO_WORD},
    '{'{CMD_FREE,   7'h20,  8'h01}, 1'b0, NO_WORD},
    '{'{CMD_FREE,   7'h40,  8'h02}, 1'b0, NO_WORD},
    '{'{CMD_FREE,   7'h3c,  8'h03}, 1'b0, NO_WORD},
    '{'{CMD_ALLOC,  7'd3,   8'h81}, 1'b0, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst_n;

  dfra_in_if  in_ch();
  dfra_out_if out_ch();

  dragonfly_round_robin_router_allocator_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Predictor state: free map, free count, pending node grants
  logic [TOTAL-1:0] node_free;
  int unsigned      free_total;
  alloc_word_t      alloc_expect[$];

  int mismatches = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit hold_req   = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Walk the groups round robin, taking the first router with usable nodes
  function automatic void predict_placement(input int unsigned size);
    logic [TOTAL-1:0] taken;
    alloc_word_t      held;
    bit               have_held;
    int unsigned      grp, placed, tries, r, k, n;
    int               rtr;
    taken     = '0;
    held      = '0;
    have_held = 1'b0;
    grp       = 0;
    placed    = 0;
    if (size == 0 || size > MAX_JOB || size > free_total) begin
      alloc_expect.push_back(FAIL_WORD);
      return;
    end
    while (placed < size) begin
      rtr   = -1;
      tries = 0;
      while (rtr < 0 && tries < GROUPS) begin
        for (r = 0; r < ROUTERS && rtr < 0; r++) begin
          for (k = 0; k < NODES_PER_ROUTER; k++) begin
            n = grp * NODES_PER_GROUP + r * NODES_PER_ROUTER + k;
            if (node_free[n] && !taken[n] && rtr < 0) rtr = r;
          end
        end
        if (rtr < 0) grp = (grp + 1) % GROUPS;
        tries++;
      end
      if (rtr < 0) break;
      for (k = 0; k < NODES_PER_ROUTER && placed < size; k++) begin
        n = grp * NODES_PER_GROUP + rtr * NODES_PER_ROUTER + k;
        if (node_free[n] && !taken[n]) begin
          taken[n] = 1'b1;
          // hold one back so the final grant can get its last flag
          if (have_held) alloc_expect.push_back(held);
          held      = '{node_id: n[NODE_W-1:0], failed: 1'b0, last: 1'b0};
          have_held = 1'b1;
          placed++;
        end
      end
      grp = (grp + 1) % GROUPS;
    end
    if (!have_held) begin
      alloc_expect.push_back(FAIL_WORD);
    end else begin
      held.last = 1'b1;
      alloc_expect.push_back(held);
    end
  endfunction

  // Apply one accepted command word to the predictor
  function automatic void absorb_word(input cmd_word_t w);
    case (w.command)
      CMD_BUSY: begin
        if (int'(w.node_index) < TOTAL && node_free[w.node_index]) begin
          node_free[w.node_index] = 1'b0;
          free_total--;
        end
      end
      CMD_FREE: begin
        if (int'(w.node_index) < TOTAL && !node_free[w.node_index]) begin
          node_free[w.node_index] = 1'b1;
          free_total++;
        end
      end
      CMD_ALLOC: predict_placement(w.job_size);
      default: ;
    endcase
  endfunction

  // Offer one word after a random gap; predict once it is taken
  task automatic offer_word(input cmd_word_t w, input bit fixed_on, input alloc_word_t fixed);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= w.command;
    in_ch.job_size   <= w.job_size;
    in_ch.node_index <= w.node_index;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (fixed_on) alloc_expect.push_back(fixed);
    else absorb_word(w);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    alloc_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (alloc_expect.size() == 0) begin
        report_mismatch("word with nothing pending, node_id", out_ch.node_id, -1);
      end else begin
        want = alloc_expect.pop_front();
        if (out_ch.node_id !== want.node_id)
          report_mismatch("node_id", out_ch.node_id, want.node_id);
        if (out_ch.failed !== want.failed)
          report_mismatch("failed", out_ch.failed, want.failed);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  // Stimulus
  initial begin
    cmd_word_t   w;
    int unsigned counted, target, roll, start, n, j, off;
    int          i, phase;
    bit          want_free;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_ALLOC;
    in_ch.job_size   = '0;
    in_ch.node_index = '0;
    node_free        = '1;
    free_total       = TOTAL;
    rst_n            = 1'b0;
    target           = TOTAL;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed words, no idling
    for (i = 0; i < DIRECTED_ROWS; i++)
      offer_word(DIRECTED[i].w, DIRECTED[i].fixed_on, DIRECTED[i].fixed);

    // random phases; each drifts the free count toward its own target
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  target = 160; end
        1: begin idle_pct = 52; stall_pct = 0;  target = 40;  end
        2: begin idle_pct = 0;  stall_pct = 52; target = 40;  hold_req = 1'b1; end
        default: begin idle_pct = 7; stall_pct = 7; target = 110; end
      endcase
      counted = 0;
      off     = 0;
      while (counted < PHASE_WORDS) begin
        off  = (free_total > target) ? free_total - target : target - free_total;
        roll = $urandom_range(99);
        // fields the command does not use stay random
        w.job_size   = SIZE_W'($urandom());
        w.node_index = NODE_W'($urandom());
        if (roll < 3) begin
          w.command = CMD_UNUSED;
        end else if (roll < ((off > 16) ? 15 : 30)) begin
          w.command = CMD_ALLOC;
          roll = $urandom_range(99);
          if (roll < 50)      w.job_size = SIZE_W'($urandom_range(8, 1));
          else if (roll < 75) w.job_size = SIZE_W'($urandom_range(32, 9));
          else if (roll < 85) w.job_size = SIZE_W'($urandom_range(MAX_JOB, 33));
          else if (roll < 93) begin
            // exact fit or one node short
            if (free_total + 1 > MAX_JOB) w.job_size = SIZE_W'(MAX_JOB);
            else w.job_size = SIZE_W'(free_total + $urandom_range(1));
          end else begin
            w.job_size = SIZE_W'($urandom_range(127));
          end
        end else begin
          // mark: mostly toward the target, and mostly on a node that it changes
          if (off > 16) want_free = (free_total > target) ^ ($urandom_range(99) < 10);
          else want_free = $urandom_range(1);
          w.command = want_free ? CMD_BUSY : CMD_FREE;
          if ($urandom_range(99) < 85) begin
            start = $urandom_range(TOTAL - 1);
            for (j = 0; j < TOTAL; j++) begin
              n = (start + j) % TOTAL;
              if (node_free[n] == want_free) break;
            end
            if (j < TOTAL) w.node_index = NODE_W'(n);
          end
        end
        offer_word(w, 1'b0, NO_WORD);
        if (w.command != CMD_UNUSED) counted++;
      end
    end

    // drain: all grants in, then a full scan's worth of quiet
    @(negedge clk) in_ch.valid <= 1'b0;
    while (alloc_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dfra_pkg.sv
rtl/core/dfra_ifs.sv
rtl/core/dfra_free_map.sv
rtl/core/dragonfly_round_robin_router_allocator_unit.sv
test/dragonfly_round_robin_router_allocator_unit_test.sv
